FILE: rtl/ipsenc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and stream text for the IPS patch record encoder.
package ipsenc_pkg;

   localparam int RECORD_BYTES_DEF = 56;
   localparam int LIMIT_W          = 6;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd56;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_RECORD_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_END   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_REC_HDR,
      ST_REC_DATA,
      ST_TAIL
   } state_type;

   // "PATCH"
   function automatic logic [7:0] head_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h50;
         3'd1:    b = 8'h41;
         3'd2:    b = 8'h54;
         3'd3:    b = 8'h43;
         3'd4:    b = 8'h48;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // "EOF"
   function automatic logic [7:0] tail_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h45;
         2'd1:    b = 8'h4F;
         2'd2:    b = 8'h46;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/ipsenc_buf.sv
`timescale 1ns / 1ps
// Pending record byte buffer: one write port, one registered read port.
module ipsenc_buf import ipsenc_pkg::*; #(
   parameter int DEPTH  = RECORD_BYTES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read, so a stalled output loses nothing
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ipsenc_ctrl.sv
`timescale 1ns / 1ps
// Record sequencer: decides on each request, replays the buffer and drives the output register.
module ipsenc_ctrl import ipsenc_pkg::*; #(
   parameter int RECORD_BYTES = RECORD_BYTES_DEF,
   parameter int ADDR_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [23:0]        req_file_addr,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_byte,
   input  logic [LIMIT_W-1:0] record_limit,
   output logic               mem_wr_en,
   output logic [ADDR_W-1:0]  mem_wr_addr,
   output logic [7:0]         mem_wr_data,
   output logic               mem_rd_en,
   output logic [ADDR_W-1:0]  mem_rd_addr,
   input  logic [7:0]         mem_rd_data
);

   localparam int CNT_W = $clog2(RECORD_BYTES + 1);
   localparam int SEQ_W = (CNT_W > 3) ? CNT_W : 3;
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   state_type   state_ff, state_in;
   logic [SEQ_W-1:0] seq_idx_ff, seq_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [23:0] start_ff, start_in;
   cmd_type     pend_cmd_ff, pend_cmd_in;
   logic [23:0] pend_addr_ff, pend_addr_in;
   logic [7:0]  pend_data_ff, pend_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             accept;
   cmd_type          cmd;
   logic [CMP_W-1:0] lim_eff;
   logic [24:0]      next_addr;
   logic             flush_need;
   logic [SEQ_W-1:0] idx_next;
   logic             data_done;
   logic [15:0]      size16;
   logic             emit;
   logic [7:0]       emit_byte;
   logic             emit_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign cmd      = cmd_type'(req_command);

   always_comb begin
      lim_eff = CMP_W'(record_limit);
      if (lim_eff == '0) begin
         lim_eff = CMP_W'(1);
      end
      if (lim_eff > CMP_W'(RECORD_BYTES)) begin
         lim_eff = CMP_W'(RECORD_BYTES);
      end
   end

   // no wrap: a byte at offset 0 never continues a record ending at the top
   assign next_addr  = {1'b0, start_ff} + 25'(count_ff);
   assign flush_need = (count_ff != '0) &&
                       ((next_addr != {1'b0, req_file_addr}) ||
                        (CMP_W'(count_ff) >= lim_eff));
   assign idx_next   = seq_idx_ff + 1'b1;
   assign data_done  = (idx_next == SEQ_W'(count_ff));
   assign size16     = 16'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_BEGIN: state_in = ST_HEAD;
                  CMD_DATA:  state_in = flush_need ? ST_REC_HDR : ST_IDLE;
                  CMD_END:   state_in = (count_ff != '0) ? ST_REC_HDR : ST_TAIL;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_HEAD: begin
            if (out_free && seq_idx_ff == SEQ_W'(4)) begin
               state_in = ST_IDLE;
            end
         end
         ST_REC_HDR: begin
            if (out_free && seq_idx_ff == SEQ_W'(4)) begin
               state_in = ST_REC_DATA;
            end
         end
         ST_REC_DATA: begin
            if (out_free && data_done) begin
               state_in = (pend_cmd_ff == CMD_END) ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (out_free && seq_idx_ff == SEQ_W'(2)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      seq_idx_in   = seq_idx_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      pend_cmd_in  = pend_cmd_ff;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      emit         = 1'b0;
      emit_byte    = 8'h00;
      emit_last    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = req_data_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_cmd_in  = cmd;
               pend_addr_in = req_file_addr;
               pend_data_in = req_data_byte;
               seq_idx_in   = '0;
               case (cmd)
                  CMD_BEGIN: begin
                     // a pending record is dropped
                     count_in = '0;
                     start_in = '0;
                  end
                  CMD_DATA: begin
                     if (!flush_need) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[ADDR_W-1:0];
                        count_in    = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           start_in = req_file_addr;
                        end
                     end
                  end
                  CMD_END: begin
                     if (count_ff == '0) begin
                        start_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_byte  = head_byte(seq_idx_ff[2:0]);
               emit_last  = (seq_idx_ff == SEQ_W'(4));
               seq_idx_in = idx_next;
            end
         end
         ST_REC_HDR: begin
            if (out_free) begin
               emit       = 1'b1;
               seq_idx_in = idx_next;
               case (seq_idx_ff[2:0])
                  3'd0:    emit_byte = start_ff[23:16];
                  3'd1:    emit_byte = start_ff[15:8];
                  3'd2:    emit_byte = start_ff[7:0];
                  3'd3:    emit_byte = size16[15:8];
                  default: emit_byte = size16[7:0];
               endcase
               if (seq_idx_ff == SEQ_W'(4)) begin
                  mem_rd_en  = 1'b1;
                  seq_idx_in = '0;
               end
            end
         end
         ST_REC_DATA: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = mem_rd_data;
               if (data_done) begin
                  seq_idx_in = '0;
                  count_in   = '0;
                  if (pend_cmd_ff == CMD_DATA) begin
                     // the held byte opens the next record
                     mem_wr_en   = 1'b1;
                     mem_wr_data = pend_data_ff;
                     count_in    = CNT_W'(1);
                     start_in    = pend_addr_ff;
                     emit_last   = 1'b1;
                  end else begin
                     start_in = '0;
                  end
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_next[ADDR_W-1:0];
                  seq_idx_in  = idx_next;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_byte  = tail_byte(seq_idx_ff[1:0]);
               emit_last  = (seq_idx_ff == SEQ_W'(2));
               seq_idx_in = idx_next;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_idx_ff   <= '0;
         count_ff     <= '0;
         start_ff     <= '0;
         pend_cmd_ff  <= CMD_BEGIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_idx_ff   <= seq_idx_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         pend_cmd_ff  <= pend_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

FILE: rtl/ips_patch_record_encoder_core.sv
`timescale 1ns / 1ps
// Top level of the IPS patch record encoder: register port, sequencer and buffer.
//
// Requests carry a command (begin, data byte, end), a 24-bit file offset and a
// data byte. Results are the bytes of the IPS stream, one per handshake;
// rsp_last_byte marks the final byte caused by a request.
// A begin request yields the 5-byte header after it is taken. A data byte that
// continues the pending record is stored in the buffer and yields nothing. A
// data byte that breaks the record (gap or full) first yields the pending
// record: 5 header bytes and n data bytes, one per cycle while rsp_stall is
// low. An end request yields any pending record and then the 3-byte trailer.
// Bytes are emitted while the receiver takes them; the buffer read port delivers
// one byte a cycle. For a request that yields bytes, req_stall stays high from
// the request until its final byte is loaded into the output register, so the
// next request enters the cycle after that while the final byte may still wait.
// rsp_stall holds the output register and pauses the sequencer; nothing drops.
// Reset clears the pending record and output register and sets record_limit
// to 56; the buffer needs no clearing pass. The limit must be written over the
// register port while no request is in progress; the block does not enforce it.
module ips_patch_record_encoder_core import ipsenc_pkg::*; #(
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [23:0]           req_file_addr,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_wr;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [7:0]         mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [7:0]         mem_rd_data;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_RECORD_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr) begin
         limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata = (paddr[2] == REG_RECORD_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;

   ipsenc_ctrl #(
      .RECORD_BYTES (RECORD_BYTES),
      .ADDR_W       (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_file_addr (req_file_addr),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .record_limit  (limit_ff),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   ipsenc_buf #(
      .DEPTH  (RECORD_BYTES),
      .ADDR_W (ADDR_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: rtl/ipsenc_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the IPS patch record encoder, bound to the top level.
module ipsenc_chk import ipsenc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_command,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_last_byte))
      else $error("stalled result changed");

   // a begin request always produces output, so the block stays busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_BEGIN) |=> req_stall)
      else $error("begin request did not occupy the block");

   // more bytes follow a non-final byte, so no new request can be taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |-> req_stall)
      else $error("request taken in the middle of a byte sequence");

   // output register is empty after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ips_patch_record_encoder_core ipsenc_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPS patch record encoder core.
module testbench;
   import ipsenc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_RECORD_LIMIT = {REG_RECORD_LIMIT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;
   localparam logic [39:0] PATCH_TEXT  = "PATCH";
   localparam logic [23:0] EOF_TEXT    = "EOF";
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int CHUNK_ITEMS  = 40;
   localparam int NUM_CHUNKS   = 12;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [23:0] addr;
      logic [7:0]  data;
   } patch_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_command = CMD_BEGIN;
   logic [23:0]           req_file_addr = '0;
   logic [7:0]            req_data_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last_byte;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // pending requests, and the expected patch stream
   patch_req_type pend_reqs[$];
   patch_req_type next_req;
   logic [7:0] exp_byte[$];
   logic       exp_last[$];

   // predictor copy of the encoder state
   logic [7:0]  store_buf[RECORD_BYTES_DEF];
   logic [6:0]  store_cnt = '0;
   logic [23:0] store_start = '0;
   logic [5:0]  limit_cfg = LIMIT_RESET;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_arm = 1'b0;
   logic hold_done = 1'b0;

   ips_patch_record_encoder_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_file_addr(req_file_addr), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_last_byte(rsp_last_byte),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_byte(input logic [7:0] b);
      exp_byte.push_back(b);
      exp_last.push_back(1'b0);
   endfunction

   function automatic void flush_pending();
      if (store_cnt != 0) begin
         push_byte(store_start[23:16]);
         push_byte(store_start[15:8]);
         push_byte(store_start[7:0]);
         push_byte(8'h00);
         push_byte({1'b0, store_cnt});
         for (int i = 0; i < store_cnt; i++)
            push_byte(store_buf[i]);
         store_cnt = '0;
      end
   endfunction

   // expected stream bytes caused by one request
   function automatic void predict_stream(input logic [1:0] cmd, input logic [23:0] addr,
                                          input logic [7:0] data);
      int   first;
      int   eff_limit;
      first = exp_byte.size();
      eff_limit = (limit_cfg == 0) ? 1 :
                  (limit_cfg > RECORD_BYTES_DEF) ? RECORD_BYTES_DEF : limit_cfg;
      case (cmd)
         CMD_BEGIN: begin
            store_cnt = '0;
            store_start = '0;
            for (int i = 4; i >= 0; i--)
               push_byte(PATCH_TEXT[8*i +: 8]);
         end
         CMD_DATA: begin
            // 25-bit sum: offset 0 never continues a record ending at the top
            if (store_cnt != 0 &&
                ({1'b0, addr} != {1'b0, store_start} + 25'(store_cnt) ||
                 store_cnt >= eff_limit))
               flush_pending();
            if (store_cnt == 0)
               store_start = addr;
            if (store_cnt < RECORD_BYTES_DEF) begin
               store_buf[store_cnt] = data;
               store_cnt++;
            end
         end
         CMD_END: begin
            flush_pending();
            store_start = '0;
            for (int i = 2; i >= 0; i--)
               push_byte(EOF_TEXT[8*i +: 8]);
         end
         default: ;
      endcase
      if (exp_byte.size() > first)
         exp_last[exp_last.size()-1] = 1'b1;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_stream(req_command, req_file_addr, req_data_byte);
         if (!req_valid || !req_stall) begin
            if (pend_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pend_reqs.pop_front();
               req_valid <= 1'b1;
               req_command <= next_req.cmd;
               req_file_addr <= next_req.addr;
               req_data_byte <= next_req.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, armed once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_byte.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected stream byte %h last %b", rsp_out_byte, rsp_last_byte);
            end else if (rsp_out_byte !== exp_byte[0] || rsp_last_byte !== exp_last[0]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: byte exp %h got %h, last exp %b got %b",
                           exp_byte[0], rsp_out_byte, exp_last[0], rsp_last_byte);
               void'(exp_byte.pop_front());
               void'(exp_last.pop_front());
            end else begin
               void'(exp_byte.pop_front());
               void'(exp_last.pop_front());
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic add_req(input logic [1:0] cmd, input logic [23:0] addr,
                          input logic [7:0] data);
      patch_req_type r;
      r.cmd = cmd;
      r.addr = addr;
      r.data = data;
      pend_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pend_reqs.size() != 0 || req_valid || exp_byte.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [5:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom()};
      word[5:0] = value;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_RECORD_LIMIT)
         limit_cfg = value;
   endtask

   // mostly contiguous runs of data with random content, plus commands and noise
   task automatic queue_random(input int n_items);
      int          made;
      int          pick;
      int          run_len;
      int          k;
      logic [23:0] a;
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            add_req(CMD_BEGIN, 24'($urandom), 8'($urandom));
            made++;
         end else if (pick < 12) begin
            add_req(CMD_END, 24'($urandom), 8'($urandom));
            made++;
         end else if (pick < 15) begin
            add_req(CMD_UNUSED, 24'($urandom), 8'($urandom));
         end else begin
            a = (pick < 22) ? 24'hFFFFFF - 24'($urandom_range(3)) : 24'($urandom);
            run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 12);
            if (run_len > n_items - made)
               run_len = n_items - made;
            for (k = 0; k < run_len; k++) begin
               add_req(CMD_DATA, a, 8'($urandom));
               made++;
               a = a + (($urandom_range(19) == 0) ? 24'd2 : 24'd1);
            end
         end
      end
   endtask

   initial begin
      logic [5:0] chunk_limit[NUM_CHUNKS];
      chunk_limit = '{6'd63, 6'd1, 6'd0, 6'd9, 6'd56, 6'd3,
                      6'd20, 6'd2, 6'd56, 6'd40, 6'd1, 6'd55};
      send_idle_pct = 7;
      recv_idle_pct = 51;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // header, a run across the top of the address space that breaks at offset 0, flush on end
      add_req(CMD_BEGIN, 24'h000000, 8'h00);
      add_req(CMD_DATA, 24'hFFFFFE, 8'hFF);
      add_req(CMD_DATA, 24'hFFFFFF, 8'h00);
      add_req(CMD_DATA, 24'h000000, 8'hA5);
      add_req(CMD_END, 24'hFFFFFF, 8'hFF);
      // end with nothing pending, then an unused command
      add_req(CMD_END, 24'h000000, 8'h00);
      add_req(CMD_UNUSED, 24'hFFFFFF, 8'hFF);
      // begin drops the pending record
      add_req(CMD_DATA, 24'h123456, 8'h5A);
      add_req(CMD_DATA, 24'h123457, 8'hC3);
      add_req(CMD_BEGIN, 24'hABCDEF, 8'h11);
      add_req(CMD_DATA, 24'h800001, 8'h7E);
      add_req(CMD_END, 24'h000000, 8'h00);
      wait_idle();

      // limit zero behaves as one
      csr_write(ADDR_RECORD_LIMIT, 6'd0);
      add_req(CMD_DATA, 24'h000010, 8'h01);
      add_req(CMD_DATA, 24'h000011, 8'h02);
      add_req(CMD_DATA, 24'h000012, 8'h03);
      add_req(CMD_END, 24'h000000, 8'h00);
      wait_idle();

      // record pending while the limit drops below its size
      csr_write(ADDR_RECORD_LIMIT, 6'd56);
      for (int i = 0; i < 5; i++)
         add_req(CMD_DATA, 24'h3FFFF0 + 24'(i), 8'h80 + 8'(i));
      wait_idle();
      csr_write(ADDR_RECORD_LIMIT, 6'd2);
      csr_write(ADDR_UNMAPPED, 6'd40);
      add_req(CMD_DATA, 24'h3FFFF5, 8'h99);
      add_req(CMD_DATA, 24'h3FFFF6, 8'h9A);
      add_req(CMD_END, 24'h000000, 8'h00);
      wait_idle();

      for (int c = 0; c < NUM_CHUNKS; c++) begin
         if (c < 4) begin
            send_idle_pct = 7;
            recv_idle_pct = 51;
         end else if (c < 8) begin
            send_idle_pct = 51;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(ADDR_RECORD_LIMIT, chunk_limit[c]);
         if (c == 8)
            hold_arm <= 1'b1;
         queue_random(CHUNK_ITEMS);
         wait_idle();
      end

      if (errors == 0 && exp_byte.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
